[rtl/core/kern_pair_search_combine_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the kerning pair lookup block
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef KERN_PAIR_SEARCH_COMBINE_MACROS_SVH
`define KERN_PAIR_SEARCH_COMBINE_MACROS_SVH

// Same-cycle implication
`define KPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define KPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/kps_pkg.sv]
// ----------------------------------------------------------------------------
// kps_pkg
// Shared codes, types and the combine function of the kerning pair lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package kps_pkg;

  // Request kinds carried in tuser
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_GLYPH = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_PAIR_TOTAL   = 2'd0;
  localparam logic [1:0] CFG_COMBINE_MODE = 2'd1;

  // Combine modes; the unused code acts as add
  localparam logic [1:0] MODE_ADD  = 2'd0;
  localparam logic [1:0] MODE_MIN  = 2'd1;
  localparam logic [1:0] MODE_OVR  = 2'd2;

  // Table entry layout
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned VAL_W   = 16;
  localparam int unsigned ENTRY_W = KEY_W + VAL_W;

  // Lookup result handed from the search unit to the top level
  typedef struct packed {
    logic             done;
    logic             hit;
    logic [VAL_W-1:0] value;
  } kps_res_t;

  // Fold a kerning value into a placement
  function automatic logic [31:0] kps_combine(input logic [1:0]  mode,
                                              input logic [31:0] place,
                                              input logic [15:0] val);
    logic [31:0] ext;
    logic [31:0] res;
    ext = {{16{val[15]}}, val};
    case (mode)
      MODE_MIN: res = ($signed(place) < $signed(ext)) ? place : ext;
      MODE_OVR: res = ext;
      default:  res = place + ext;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

[rtl/core/kern_pair_search_combine.sv]
// Kerning pair lookup for a glyph run. Load requests (tuser 0) write one table
// entry in the cycle they are accepted, and the input stays ready for the next
// request. Glyph requests (tuser 1) give one result each. A run-start glyph does
// no lookup: its result passes through the finish state into the output
// register, and the input is ready again as the result is loaded. Any other
// glyph binary-searches the first pair_total entries of the table, clamped to
// the table depth, for the pair formed with the previous glyph. The result is
// presented in the same cycle as the input is ready again. The single table
// read port gives the search one probe per cycle. The input is not ready while
// a glyph is being processed. A finished result sits in an output register,
// and the next request is taken while it waits.
`default_nettype none

`include "kern_pair_search_combine_macros.svh"

// ----------------------------------------------------------------------------
// kern_pair_search_combine
// Kerning pair table with lower-bound search and placement combine.
// ----------------------------------------------------------------------------
module kern_pair_search_combine #(
  parameter int unsigned PAIR_DEPTH = 1024
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  // Request stream
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata, low to high: entry_slot[9:0], lead_id[25:10], trail_id[41:26],
  // kern_amount[57:42], glyph_id[73:58], placement_in[105:74], run_start[106]
  input  wire [111:0]  s_axis_tdata,
  // tuser: req_type[0]
  input  wire [0:0]    s_axis_tuser,
  // Result stream
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // tdata, low to high: placement_out[31:0], pair_hit[32], run_nonzero[33]
  output logic [39:0]  m_axis_tdata,
  // Configuration writes
  input  wire          cfg_valid_i,
  output logic         cfg_ready_o,
  input  wire [1:0]    cfg_addr_i,
  input  wire [10:0]   cfg_data_i
);
  import kps_pkg::*;

  localparam int unsigned AW    = $clog2(PAIR_DEPTH);
  localparam int unsigned CNT_W = $clog2(PAIR_DEPTH + 1);

  typedef enum logic [2:0] {
    T_IDLE   = 3'b001,
    T_SEARCH = 3'b010,
    T_FINISH = 3'b100
  } top_state_e;

  // Request fields
  logic [9:0]  entry_slot;
  logic [15:0] lead_id, trail_id, kern_amount, glyph_id;
  logic [31:0] placement_in;
  logic        run_start;
  logic        req_type;

  assign entry_slot   = s_axis_tdata[9:0];
  assign lead_id      = s_axis_tdata[25:10];
  assign trail_id     = s_axis_tdata[41:26];
  assign kern_amount  = s_axis_tdata[57:42];
  assign glyph_id     = s_axis_tdata[73:58];
  assign placement_in = s_axis_tdata[105:74];
  assign run_start    = s_axis_tdata[106];
  assign req_type     = s_axis_tuser[0];

  top_state_e        state_q, state_d;
  logic [10:0]       pair_total_q;
  logic [1:0]        mode_q;
  logic [15:0]       prior_q;
  logic              nonzero_q, nonzero_d;
  logic [31:0]       place_q, place_d;
  logic              hit_q, hit_d;
  logic              m_valid_q, m_valid_d;
  logic [31:0]       m_place_q;
  logic              m_hit_q, m_nz_q;

  logic              accept, load_we, srch_start, out_free, out_load;
  logic [CNT_W-1:0]  count;
  logic [AW-1:0]     raddr;
  logic [ENTRY_W-1:0] rdata;
  logic [31:0]       combined;
  kps_res_t          srch_res;

  assign s_axis_tready = (state_q == T_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign load_we       = accept && (req_type == REQ_LOAD)
                         && (32'(entry_slot) < 32'(PAIR_DEPTH));
  assign srch_start    = accept && (req_type == REQ_GLYPH) && !run_start;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign out_load      = (state_q == T_FINISH) && out_free;
  assign cfg_ready_o   = 1'b1;

  // Clamp the pair count to the table depth
  always_comb begin
    if (32'(pair_total_q) > 32'(PAIR_DEPTH)) begin
      count = CNT_W'(PAIR_DEPTH);
    end else begin
      count = CNT_W'(pair_total_q);
    end
  end

  kps_pair_mem #(
    .PAIR_DEPTH (PAIR_DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (AW'(entry_slot)),
    .wdata_i ({lead_id, trail_id, kern_amount}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  kps_lb_search #(
    .PAIR_DEPTH (PAIR_DEPTH)
  ) u_search (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (srch_start),
    .key_i   ({prior_q, glyph_id}),
    .count_i (count),
    .rdata_i (rdata),
    .raddr_o (raddr),
    .res_o   (srch_res)
  );

  assign combined = kps_combine(mode_q, place_q, srch_res.value);

  // Request sequencing
  always_comb begin
    state_d   = state_q;
    nonzero_d = nonzero_q;
    place_d   = place_q;
    hit_d     = hit_q;
    unique case (state_q)
      T_IDLE: begin
        if (accept && (req_type == REQ_GLYPH)) begin
          place_d = placement_in;
          hit_d   = 1'b0;
          if (run_start) begin
            nonzero_d = 1'b0;
            state_d   = T_FINISH;
          end else begin
            state_d = T_SEARCH;
          end
        end
      end
      T_SEARCH: begin
        if (srch_res.done) begin
          state_d = T_FINISH;
          if (srch_res.hit) begin
            hit_d   = 1'b1;
            place_d = combined;
            if (combined != '0) begin
              nonzero_d = 1'b1;
            end
          end
        end
      end
      T_FINISH: begin
        if (out_free) begin
          state_d = T_IDLE;
        end
      end
      default: state_d = T_IDLE;
    endcase
  end

  // Output register: load a finished result, drop it once taken
  always_comb begin
    m_valid_d = m_valid_q;
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= T_IDLE;
      pair_total_q <= '0;
      mode_q       <= MODE_ADD;
      prior_q      <= '0;
      nonzero_q    <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      nonzero_q <= nonzero_d;
      m_valid_q <= m_valid_d;
      if (accept && (req_type == REQ_GLYPH)) begin
        prior_q <= glyph_id;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_addr_i)
          CFG_PAIR_TOTAL:   pair_total_q <= cfg_data_i;
          CFG_COMBINE_MODE: mode_q       <= cfg_data_i[1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    place_q <= place_d;
    hit_q   <= hit_d;
    if (out_load) begin
      m_place_q <= place_q;
      m_hit_q   <= hit_q;
      m_nz_q    <= nonzero_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {6'b0, m_nz_q, m_hit_q, m_place_q};

  `KPS_ASSERT_NOW(a_busy_not_ready, state_q != T_IDLE, !s_axis_tready, "input ready while busy")
  `KPS_ASSERT_NOW(a_done_in_search, srch_res.done, state_q == T_SEARCH, "search done out of turn")
  `KPS_ASSERT_NEXT(a_result_loaded, out_load, m_axis_tvalid, "finished result not presented")
  `KPS_ASSERT_NOW(a_hit_needs_lookup, out_load && hit_q, nonzero_q == (nonzero_q || place_q != '0),
                  "nonzero flag missed a hit")

endmodule

`default_nettype wire

[rtl/core/kps_pair_mem.sv]
// ----------------------------------------------------------------------------
// kps_pair_mem
// Pair table: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module kps_pair_mem #(
  parameter int unsigned PAIR_DEPTH = 1024
) (
  input  wire                                clk_i,
  input  wire                                we_i,
  input  wire [$clog2(PAIR_DEPTH)-1:0]       waddr_i,
  input  wire [kps_pkg::ENTRY_W-1:0]         wdata_i,
  input  wire [$clog2(PAIR_DEPTH)-1:0]       raddr_i,
  output logic [kps_pkg::ENTRY_W-1:0]        rdata_o
);
  import kps_pkg::*;

  logic [ENTRY_W-1:0] mem [PAIR_DEPTH];

  // Write one entry per load request
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read every cycle, data valid the cycle after the address
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

[rtl/core/kps_lb_search.sv]
// ----------------------------------------------------------------------------
// kps_lb_search
// Lower-bound binary search over the pair table, one probe per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module kps_lb_search #(
  parameter int unsigned PAIR_DEPTH = 1024
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  start_i,
  input  wire [kps_pkg::KEY_W-1:0]             key_i,
  input  wire [$clog2(PAIR_DEPTH+1)-1:0]       count_i,
  input  wire [kps_pkg::ENTRY_W-1:0]           rdata_i,
  output logic [$clog2(PAIR_DEPTH)-1:0]        raddr_o,
  output kps_pkg::kps_res_t                    res_o
);
  import kps_pkg::*;

  localparam int unsigned AW    = $clog2(PAIR_DEPTH);
  localparam int unsigned CNT_W = $clog2(PAIR_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_STEP = 2'b10
  } srch_state_e;

  srch_state_e        state_q, state_d;
  logic [CNT_W-1:0]   lo_q, lo_d;
  logic [CNT_W-1:0]   n_q, n_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [KEY_W-1:0]   key_q, key_d;
  logic [CNT_W-1:0]   half;
  logic [CNT_W-1:0]   probe;
  logic [KEY_W-1:0]   ent_key;

  assign ent_key = rdata_i[ENTRY_W-1:VAL_W];
  assign half    = n_q >> 1;

  // Compare step: start a search, narrow the window and aim the next probe, or report the result
  always_comb begin
    state_d = state_q;
    lo_d    = lo_q;
    n_d     = n_q;
    cnt_d   = cnt_q;
    key_d   = key_q;
    res_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          lo_d    = '0;
          n_d     = count_i;
          cnt_d   = count_i;
          key_d   = key_i;
          state_d = S_STEP;
        end
      end
      S_STEP: begin
        if (n_q == '0) begin
          res_o.done  = 1'b1;
          res_o.hit   = (lo_q < cnt_q) && (ent_key == key_q);
          res_o.value = rdata_i[VAL_W-1:0];
          state_d     = S_IDLE;
        end else if (ent_key < key_q) begin
          lo_d = lo_q + half + CNT_W'(1);
          n_d  = n_q - half - CNT_W'(1);
        end else begin
          n_d = half;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Probe address follows the next window
  assign probe   = lo_d + (n_d >> 1);
  assign raddr_o = probe[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    n_q   <= n_d;
    cnt_q <= cnt_d;
    key_q <= key_d;
  end

endmodule

`default_nettype wire
